// ===== src/vsl_pkg.sv =====
// vsl_pkg: shared constants for the vector step limiter.
// No dependencies.
`default_nettype none

package vsl_pkg;

    // Number of vector axes (x, y, z).
    localparam int unsigned AXES = 3;

    // Number of coordinate fields in one input transfer (current and goal point).
    localparam int unsigned IN_COORDS = 2 * AXES;

endpackage : vsl_pkg

`default_nettype wire

// ===== src/vector_step_limiter_top.sv =====
// vector_step_limiter_top: pipelined "move towards" for 3D fixed-point points.
// Depends on vsl_pkg (axis count).
`default_nettype none

// Channel     Dir  Handshake                 Payload
// s_ (input)  in   s_tvalid / s_tready       s_tdata: cur_x,cur_y,cur_z,goal_x,goal_y,goal_z
// m_ (output) out  m_tvalid / m_tready       m_tdata: next_x,next_y,next_z; m_tuser: reached
// cfg_        in   cfg_valid / cfg_ready     cfg_data: step_limit
//
// One transfer in per cycle, one result out per cycle, while m_ does not stall.
// A result passes these register stages after its input transfer: input,
// square/product, sum, COORD_BITS+1 root stages, divide load, COORD_BITS+1
// divide stages, result, output.
// The root and quotient units resolve one bit per stage, which sets the depth.
// A stall on m_ fills a one-entry skid register; s_tready drops the cycle
// after and the whole pipe freezes, nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipe and loads step_limit = 1.0.
// cfg_ready is always high; the user must write step_limit only while the pipe is empty; the block does not enforce it.

module vector_step_limiter_top #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // config write
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [COORD_BITS-1:0]            cfg_data,     // step_limit
    // input stream
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // [cur_x, cur_y, cur_z, goal_x, goal_y, goal_z] from bit 0 up, zero filled
    input  wire  [((6*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // output stream
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // [next_x, next_y, next_z] from bit 0 up, zero filled
    output logic [((3*COORD_BITS+7)/8)*8-1:0] m_tdata,
    output logic                             m_tuser       // reached
);

    localparam int C   = COORD_BITS;
    localparam int AX  = vsl_pkg::AXES;
    localparam int DM  = C + 1;          // delta magnitude bits
    localparam int SQW = 2 * DM;         // one squared delta
    localparam int RW  = C + 1;          // root (distance) bits
    localparam int SW  = 2 * RW;         // squared length bits
    localparam int PW  = DM + C;         // |d| * |limit|
    localparam int QW  = C + 1;          // quotient bits (bounded by 2*|limit|)
    localparam int OW  = ((3*C+7)/8)*8;

    typedef struct packed {
        logic [AX-1:0][C-1:0]  cur;
        logic [AX-1:0][C-1:0]  goal;
        logic [AX-1:0]         neg;    // offset sign
        logic [AX-1:0][PW-1:0] prod;
        logic                  near;   // result is the goal
    } side_t;

    // ---------------- configuration ----------------
    logic [C-1:0] lim_reg;
    logic         lim_neg;
    logic [C-1:0] lim_mag;

    assign cfg_ready = 1'b1;
    assign lim_neg   = lim_reg[C-1];
    assign lim_mag   = lim_neg ? (~lim_reg + C'(1)) : lim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_reg <= C'(1) << FRAC_BITS;
        end else if (cfg_valid) begin
            lim_reg <= cfg_data;
        end
    end

    // ---------------- flow control ----------------
    logic skid_vld_reg;
    logic en;

    assign en       = ~skid_vld_reg;
    assign s_tready = en;

    // ---------------- stage 1: deltas ----------------
    logic                  s1_vld_reg;
    logic [AX-1:0][C-1:0]  s1_cur_reg, s1_goal_reg;
    logic [AX-1:0][DM-1:0] s1_mag_reg;
    logic [AX-1:0]         s1_neg_reg;
    logic [AX-1:0][C-1:0]  s1_cur_next, s1_goal_next;
    logic [AX-1:0][DM-1:0] s1_mag_next;
    logic [AX-1:0]         s1_neg_next;

    always_comb begin
        logic signed [C:0] d;
        for (int a = 0; a < AX; a++) begin
            s1_cur_next[a]  = s_tdata[a*C +: C];
            s1_goal_next[a] = s_tdata[(a+AX)*C +: C];
            d = $signed({s1_goal_next[a][C-1], s1_goal_next[a]})
              - $signed({s1_cur_next[a][C-1], s1_cur_next[a]});
            s1_mag_next[a] = d[C] ? DM'(-d) : DM'(d);
            s1_neg_next[a] = d[C] ^ lim_neg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_cur_reg  <= s1_cur_next;
            s1_goal_reg <= s1_goal_next;
            s1_mag_reg  <= s1_mag_next;
            s1_neg_reg  <= s1_neg_next;
        end
    end

    // ---------------- stage 2: squares and products ----------------
    logic                   s2_vld_reg;
    logic [AX-1:0][C-1:0]   s2_cur_reg, s2_goal_reg;
    logic [AX-1:0]          s2_neg_reg;
    logic [AX-1:0][SQW-1:0] s2_sq_reg;
    logic [AX-1:0][PW-1:0]  s2_prod_reg;
    logic [2*C-1:0]         s2_lsq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (en) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_cur_reg  <= s1_cur_reg;
            s2_goal_reg <= s1_goal_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_lsq_reg  <= {{C{1'b0}}, lim_mag} * {{C{1'b0}}, lim_mag};
            for (int a = 0; a < AX; a++) begin
                s2_sq_reg[a]   <= {{DM{1'b0}}, s1_mag_reg[a]} * {{DM{1'b0}}, s1_mag_reg[a]};
                s2_prod_reg[a] <= {{C{1'b0}}, s1_mag_reg[a]} * {{DM{1'b0}}, lim_mag};
            end
        end
    end

    // ---------------- stage 3: squared length, near test ----------------
    logic [SW-1:0] s3_sum;
    side_t         s3_side;

    assign s3_sum = SW'(s2_sq_reg[0]) + SW'(s2_sq_reg[1]) + SW'(s2_sq_reg[2]);

    always_comb begin
        s3_side.cur  = s2_cur_reg;
        s3_side.goal = s2_goal_reg;
        s3_side.neg  = s2_neg_reg;
        s3_side.prod = s2_prod_reg;
        s3_side.near = (s3_sum == '0) || (!lim_neg && (s3_sum < SW'(s2_lsq_reg)));
    end

    // ---------------- square root: one bit per stage ----------------
    logic          sq_vld_reg  [0:RW];
    side_t         sq_side_reg [0:RW];
    logic [SW-1:0] sq_rad_reg  [0:RW];
    logic [RW:0]   sq_rem_reg  [0:RW];
    logic [RW-1:0] sq_root_reg [0:RW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg[0] <= 1'b0;
        end else if (en) begin
            sq_vld_reg[0] <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_side_reg[0] <= s3_side;
            sq_rad_reg[0]  <= s3_sum;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < RW; j++) begin : g_sqrt
        logic [RW+2:0] cat, trial, diff;
        logic          ge;

        assign cat   = {sq_rem_reg[j], sq_rad_reg[j][SW-1 -: 2]};
        assign trial = {1'b0, sq_root_reg[j], 2'b01};
        assign ge    = cat >= trial;
        assign diff  = cat - trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld_reg[j+1] <= 1'b0;
            end else if (en) begin
                sq_vld_reg[j+1] <= sq_vld_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_side_reg[j+1] <= sq_side_reg[j];
                sq_rad_reg[j+1]  <= sq_rad_reg[j] << 2;
                sq_rem_reg[j+1]  <= ge ? diff[RW:0] : cat[RW:0];
                sq_root_reg[j+1] <= {sq_root_reg[j][RW-2:0], ge};
            end
        end
    end

    // ---------------- quotient: one bit per stage, three lanes ----------------
    logic                  dv_vld_reg  [0:QW];
    side_t                 dv_side_reg [0:QW];
    logic [RW-1:0]         dv_dist_reg [0:QW];
    logic [AX-1:0][RW-1:0] dv_rem_reg  [0:QW];
    logic [AX-1:0][QW-1:0] dv_q_reg    [0:QW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld_reg[0] <= 1'b0;
        end else if (en) begin
            dv_vld_reg[0] <= sq_vld_reg[RW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_side_reg[0] <= sq_side_reg[RW];
            dv_dist_reg[0] <= sq_root_reg[RW];
            for (int a = 0; a < AX; a++) begin
                // high part is below the distance since the quotient fits QW bits
                dv_rem_reg[0][a] <= RW'(sq_side_reg[RW].prod[a][PW-1:QW]);
                dv_q_reg[0][a]   <= '0;
            end
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [AX-1:0][RW:0]   cat;
        logic [AX-1:0][RW:0]   diff;
        logic [AX-1:0]         ge;
        logic [AX-1:0][RW-1:0] rem_next;

        always_comb begin
            for (int a = 0; a < AX; a++) begin
                cat[a]      = {dv_rem_reg[k][a], dv_side_reg[k].prod[a][QW-1-k]};
                ge[a]       = cat[a] >= {1'b0, dv_dist_reg[k]};
                diff[a]     = cat[a] - {1'b0, dv_dist_reg[k]};
                rem_next[a] = ge[a] ? diff[a][RW-1:0] : cat[a][RW-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_side_reg[k+1] <= dv_side_reg[k];
                dv_dist_reg[k+1] <= dv_dist_reg[k];
                dv_rem_reg[k+1]  <= rem_next;
                for (int a = 0; a < AX; a++) begin
                    dv_q_reg[k+1][a] <= {dv_q_reg[k][a][QW-2:0], ge[a]};
                end
            end
        end
    end

    // ---------------- result stage: sign, add, saturate or take goal ----------------
    side_t                 fin_side;
    logic [AX-1:0][QW-1:0] fin_q;
    logic [AX-1:0][C-1:0]  res_next;
    logic                  reach_next;

    assign fin_side = dv_side_reg[QW];
    assign fin_q    = dv_q_reg[QW];

    always_comb begin
        logic signed [C+1:0] off;
        logic signed [C+1:0] sum;
        reach_next = 1'b1;
        for (int a = 0; a < AX; a++) begin
            off = $signed({1'b0, fin_q[a]});
            if (fin_side.neg[a]) begin
                off = -off;
            end
            sum = $signed({{2{fin_side.cur[a][C-1]}}, fin_side.cur[a]}) + off;
            if (fin_side.near) begin
                res_next[a] = fin_side.goal[a];
            end else if (sum[C+1] == 1'b0 && sum[C:C-1] != 2'b00) begin
                res_next[a] = {1'b0, {(C-1){1'b1}}};
            end else if (sum[C+1] == 1'b1 && sum[C:C-1] != 2'b11) begin
                res_next[a] = {1'b1, {(C-1){1'b0}}};
            end else begin
                res_next[a] = sum[C-1:0];
            end
            if (res_next[a] != fin_side.goal[a]) begin
                reach_next = 1'b0;
            end
        end
    end

    logic                 rs_vld_reg;
    logic [AX-1:0][C-1:0] rs_res_reg;
    logic                 rs_reach_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rs_vld_reg <= 1'b0;
        end else if (en) begin
            rs_vld_reg <= dv_vld_reg[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rs_res_reg   <= res_next;
            rs_reach_reg <= reach_next;
        end
    end

    // ---------------- output register with skid ----------------
    logic                 out_vld_reg;
    logic [AX-1:0][C-1:0] out_res_reg, skid_res_reg;
    logic                 out_reach_reg, skid_reach_reg;
    logic                 push, take;

    assign push = en & rs_vld_reg;
    assign take = out_vld_reg & m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!out_vld_reg || take) begin
            if (skid_vld_reg) begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                out_vld_reg  <= push;
            end
        end else if (push) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_vld_reg || take) begin
            if (skid_vld_reg) begin
                out_res_reg   <= skid_res_reg;
                out_reach_reg <= skid_reach_reg;
            end else begin
                out_res_reg   <= rs_res_reg;
                out_reach_reg <= rs_reach_reg;
            end
        end else if (push) begin
            skid_res_reg   <= rs_res_reg;
            skid_reach_reg <= rs_reach_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OW'(out_res_reg);
    assign m_tuser  = out_reach_reg;

endmodule : vector_step_limiter_top

`default_nettype wire

// ===== verif/vector_step_limiter_top_tb.sv =====
// vector_step_limiter_top_tb: self-checking bench for the 3D move-toward pipeline.
// Depends on vector_step_limiter_top (and vsl_pkg); exact wide-integer predictor inside.
`timescale 1ns / 1ps

module vector_step_limiter_top_tb;

    localparam int CB       = 32;
    localparam int FB       = 16;
    localparam int LATENCY  = CB * 2 + 8;
    localparam int S_W      = ((6 * CB + 7) / 8) * 8;
    localparam int M_W      = ((3 * CB + 7) / 8) * 8;

    typedef logic signed [CB-1:0] coord_t;

    // one predicted result: next point plus reached flag
    typedef struct {
        coord_t pos[vsl_pkg::AXES];
        logic   hit;
    } point_result_t;

    logic            aclk;
    logic            aresetn;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [CB-1:0]   cfg_data;
    logic            s_tvalid;
    logic            s_tready;
    logic [S_W-1:0]  s_tdata;   // cur_x, cur_y, cur_z, goal_x, goal_y, goal_z from bit 0
    logic            m_tvalid;
    logic            m_tready;
    logic [M_W-1:0]  m_tdata;   // next_x, next_y, next_z from bit 0
    logic            m_tuser;   // reached

    vector_step_limiter_top #(.COORD_BITS(CB), .FRAC_BITS(FB)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // bench state
    coord_t        step_limit_q;          // mirror of the step register
    point_result_t pending_points[$];     // expected results, oldest first
    int            mismatches;
    int            hold_cycles;           // long receiver hold-off, counted at negedge
    int            rx_wait;               // per-result receiver stall
    logic          rx_bursty;             // when low the receiver adds no per-result stall

    always begin
        aclk = 1'b0; #4;
        aclk = 1'b1; #4;
    end

    task automatic report(input string what);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    // Exact move-toward: d = goal - cur, S = |d|^2; goal when S is zero or the
    // non-negative limit exceeds the distance, else cur + d*L/floor(sqrt(S)), saturated.
    function automatic point_result_t calc_next_point(input logic [S_W-1:0] pl,
                                                      input coord_t lim);
        point_result_t r;
        coord_t        c[vsl_pkg::AXES], g[vsl_pkg::AXES];
        longint        dd[vsl_pkg::AXES];
        logic [63:0]   mag[vsl_pkg::AXES];
        logic [63:0]   lmag, root_s, t, q;
        logic [127:0]  s, lsq;
        longint        off, v;
        for (int i = 0; i < vsl_pkg::AXES; i++) begin
            c[i] = pl[i*CB +: CB];
            g[i] = pl[(i+vsl_pkg::AXES)*CB +: CB];
            dd[i] = longint'(g[i]) - longint'(c[i]);
            mag[i] = dd[i] < 0 ? 64'(-dd[i]) : 64'(dd[i]);
        end
        s = '0;
        for (int i = 0; i < vsl_pkg::AXES; i++) s += 128'(mag[i]) * 128'(mag[i]);
        lmag = lim < 0 ? 64'(-longint'(lim)) : 64'(longint'(lim));
        lsq  = 128'(lmag) * 128'(lmag);
        if (s == 0 || (lim >= 0 && s < lsq)) begin
            for (int i = 0; i < vsl_pkg::AXES; i++) r.pos[i] = g[i];
        end else begin
            root_s = '0;
            for (int b = 50; b >= 0; b--) begin
                t = root_s | (64'd1 << b);
                if (128'(t) * 128'(t) <= s) root_s = t;
            end
            for (int i = 0; i < vsl_pkg::AXES; i++) begin
                q = 64'((128'(mag[i]) * 128'(lmag)) / 128'(root_s));
                off = longint'(q);
                if ((dd[i] < 0) != (lim < 0)) off = -off;
                v = longint'(c[i]) + off;
                if (v > 64'sd2147483647) v = 64'sd2147483647;
                if (v < -64'sd2147483648) v = -64'sd2147483648;
                r.pos[i] = coord_t'(v);
            end
        end
        r.hit = 1'b1;
        for (int i = 0; i < vsl_pkg::AXES; i++) if (r.pos[i] != g[i]) r.hit = 1'b0;
        return r;
    endfunction

    function automatic logic [S_W-1:0] pack_pair(input coord_t cx, cy, cz, gx, gy, gz);
        return {gz, gy, gx, cz, cy, cx};
    endfunction

    // Input monitor: every accepted transfer queues its prediction.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            pending_points.push_back(calc_next_point(s_tdata, step_limit_q));
    end

    // Result checker: compare each output transfer with the oldest prediction.
    always @(posedge aclk) begin
        point_result_t want;
        coord_t        got;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_points.size() == 0) begin
                report("result transfer with nothing expected");
            end else begin
                want = pending_points.pop_front();
                for (int i = 0; i < vsl_pkg::AXES; i++) begin
                    got = m_tdata[i*CB +: CB];
                    if (got !== want.pos[i])
                        report($sformatf("axis %0d got %0d want %0d", i, got, want.pos[i]));
                end
                if (m_tuser !== want.hit)
                    report($sformatf("reached got %b want %b", m_tuser, want.hit));
            end
            rx_wait = rx_bursty ? $urandom_range(0, 7) : 0;
        end
    end

    // Receiver ready: long hold-off first, then per-result stall.
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Offer one point pair after the given gap; returns after the transfer.
    task automatic send_pair(input logic [S_W-1:0] pl, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pl;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    // Stop offering and wait for the pipe to drain before touching the register.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_step_limit(input coord_t lim);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= lim;
        do @(posedge aclk); while (!cfg_ready);
        step_limit_q = lim;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_gap();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
    endfunction

    // Random pair: mostly goals near the current point, some fully random.
    function automatic logic [S_W-1:0] random_pair();
        coord_t c[vsl_pkg::AXES], g[vsl_pkg::AXES];
        int     sc;
        sc = $urandom_range(0, 4);
        for (int i = 0; i < vsl_pkg::AXES; i++) begin
            c[i] = $urandom;
            case (sc)
                0: g[i] = $urandom;
                1: g[i] = c[i] + coord_t'($urandom_range(0, 262144)) - 131072;
                2: g[i] = c[i] + coord_t'($urandom_range(0, 4096)) - 2048;
                3: g[i] = (i == 0) ? c[i] + coord_t'($urandom_range(0, 131072)) : c[i];
                default: g[i] = c[i] + coord_t'($urandom) / 256;
            endcase
        end
        if ($urandom_range(0, 15) == 0) g = c;
        return pack_pair(c[0], c[1], c[2], g[0], g[1], g[2]);
    endfunction

    // Corner cases at reset limit and a few chosen limits.
    task automatic test_directed();
        localparam coord_t MX = 32'sh7fffffff;
        localparam coord_t MN = 32'sh80000000;
        // zero distance
        send_pair(pack_pair(0, 0, 0, 0, 0, 0), 0);
        send_pair(pack_pair(MX, MN, -1, MX, MN, -1), 0);
        // far apart extremes at the reset limit
        send_pair(pack_pair(MN, MN, MN, MX, MX, MX), 1);
        send_pair(pack_pair(MX, MX, MX, MN, MN, MN), 0);
        send_pair(pack_pair(MX, 0, MN, MN, -1, MX), 0);
        // inside the limit: snaps to goal
        send_pair(pack_pair(100, 200, 300, 1000, -200, 7), 2);
        // exact step: 3-4-0 triangle with 5.0 limit
        write_step_limit(32'sd5 <<< FB);
        send_pair(pack_pair(0, 0, 0, 32'sd3 <<< FB, 32'sd4 <<< FB, 0), 0);
        send_pair(pack_pair(65536, 0, 0, 65536 + (32'sd3 <<< FB), 0, -(32'sd4 <<< FB)), 0);
        send_pair(pack_pair(0, 0, 0, 32'sd30 <<< FB, 32'sd40 <<< FB, 0), 0);
        // zero limit: stays put
        write_step_limit(0);
        send_pair(pack_pair(12345, -6789, 42, -1, 99999, MX), 0);
        send_pair(pack_pair(MN, MX, 0, MX, MN, 0), 3);
        send_pair(pack_pair(5, 5, 5, 5, 5, 5), 0);
        // negative limits push away and saturate
        write_step_limit(MN);
        send_pair(pack_pair(MX - 10, MN + 10, 0, MN, MX, 1), 0);
        send_pair(pack_pair(0, 0, 0, 1, 0, 0), 0);
        send_pair(pack_pair(7, 7, 7, 7, 7, 7), 0);
        write_step_limit(-(32'sd2 <<< FB));
        send_pair(pack_pair(MX, MN, 0, MX - 65536, MN + 65536, 0), 0);
        send_pair(pack_pair(100, 100, 100, -100, 300, 100), 0);
        // largest positive limit
        write_step_limit(MX);
        send_pair(pack_pair(MN, MN, MN, MX, MX, MX), 0);
        send_pair(pack_pair(MN, 0, 0, MX, 0, 0), 0);
        send_pair(pack_pair(-5, 9, 1, 800000, -40000, 3), 0);
        stop_sending();
    endtask

    task automatic test_random_at(input coord_t lim, input int n);
        write_step_limit(lim);
        rx_bursty = ($urandom_range(0, 3) != 0);
        for (int k = 0; k < n; k++) begin
            if (k % 60 == 59) rx_bursty = ~rx_bursty;
            send_pair(random_pair(), rx_bursty ? pick_gap() : 0);
        end
        rx_bursty = 1'b1;
        stop_sending();
    endtask

    // Receiver holds off long enough that the pipe fills and s_tready drops.
    task automatic test_backpressure();
        write_step_limit(coord_t'($urandom_range(0, 1 << 20)));
        hold_cycles = 400;
        for (int k = 0; k < 150; k++) send_pair(random_pair(), 0);
        stop_sending();
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        mismatches  = 0;
        hold_cycles = 0;
        rx_wait     = 0;
        rx_bursty   = 1'b1;
        step_limit_q = coord_t'(1) <<< FB;   // register comes out of reset at 1.0
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_random_at_reset();
        test_directed();
        test_random_at(0, 150);
        test_random_at(32'sh7fffffff, 150);
        test_random_at(32'sh80000000, 150);
        test_random_at(coord_t'($urandom_range(1, 1 << 18)), 180);
        test_random_at(-coord_t'($urandom_range(1, 1 << 18)), 180);
        test_random_at(coord_t'($urandom), 100);
        test_backpressure();

        drain();
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // first random phase runs with the register untouched since reset
    task automatic test_random_at_reset();
        for (int k = 0; k < 100; k++) send_pair(random_pair(), pick_gap());
        stop_sending();
    endtask

    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/vsl_pkg.sv
src/vector_step_limiter_top.sv
verif/vector_step_limiter_top_tb.sv
